// ===== sv/cpt_pkg.sv =====
// shared types, constants and register indexes for the command penalty throttle
`default_nettype none

package cpt_pkg;

	localparam int unsigned DEF_USER_SLOTS = 256;

	localparam int unsigned SLOT_W    = 8;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned CLASS_W   = 2;
	localparam int unsigned COST_W    = 16;
	localparam int unsigned LIMIT_W   = 8;
	localparam int unsigned PENALTY_W = 20;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned PROD_W    = TIME_W + COST_W;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned IN_DATA_W   = 40;
	localparam int unsigned OUT_DATA_W  = 32;

	localparam logic [PENALTY_W-1:0] PENALTY_BLOCK = PENALTY_W'(10000);
	localparam logic [PENALTY_W-1:0] PENALTY_MAX   = '1;
	localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BURST_LIMIT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_COST  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_JOIN_COST    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MESSAGE_COST = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NOTICE_COST  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_RECOVER_RATE = 3'd5;

	localparam logic [LIMIT_W-1:0] RST_BURST_LIMIT  = 8'd10;
	localparam logic [COST_W-1:0]  RST_NORMAL_COST  = 16'd1;
	localparam logic [COST_W-1:0]  RST_JOIN_COST    = 16'd300;
	localparam logic [COST_W-1:0]  RST_MESSAGE_COST = 16'd200;
	localparam logic [COST_W-1:0]  RST_NOTICE_COST  = 16'd100;
	localparam logic [COST_W-1:0]  RST_RECOVER_RATE = 16'd1000;

	// command classes
	localparam logic [CLASS_W-1:0] CLS_NORMAL  = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_JOIN    = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_MESSAGE = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_NOTICE  = 2'd3;

	typedef struct packed {
		logic [LIMIT_W-1:0] burst_limit;
		logic [COST_W-1:0]  normal_cost;
		logic [COST_W-1:0]  join_cost;
		logic [COST_W-1:0]  message_cost;
		logic [COST_W-1:0]  notice_cost;
		logic [COST_W-1:0]  recover_rate;
	} cfg_regs_t;

	// classified command waiting for the back end
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now;
		logic [COST_W-1:0] cost;
		logic              in_range;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0]    last_seen;
		logic [PENALTY_W-1:0] penalty;
		logic [COUNT_W-1:0]   count;
	} entry_t;

	typedef struct packed {
		logic                 allowed;
		logic [PENALTY_W-1:0] penalty_now;
		logic [COUNT_W-1:0]   second_count;
	} result_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_MUL,
		BK_DRAIN,
		BK_COMMIT
	} back_state_t;

endpackage

`default_nettype wire

// ===== sv/command_penalty_throttle.sv =====
// Per-user command throttle (leaky bucket) with a per-second burst counter.
//
// Commands arrive on the s_ stream: tdata carries the user slot and the time
// in seconds, tuser the command class. Each transfer yields exactly one verdict
// on the m_ stream: allowed flag, the user's penalty after the command and the
// count of commands seen in this second. Registers go in over the cfg channel,
// always ready; the user must write only with no command in flight, unchecked.
//
// A command enters a two-entry queue in the cycle it is taken; the back end
// then takes it through five steps (pop, table read, drain multiply, drain
// floor, update and write back), and the result waits in COMMIT while the
// output register is still full. A command is popped only once the last is
// committed. A slot at or past USER_SLOTS skips the table, going from the pop
// straight to update. The table read-modify-write serialises the commands.
//
// After reset the user table is cleared one entry per cycle and s_tready stays
// low meanwhile. When the receiver stalls, the result waits in the output
// register and the queue fills, then s_tready drops.
`default_nettype none

module command_penalty_throttle #(
	parameter int unsigned USER_SLOTS = cpt_pkg::DEF_USER_SLOTS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [7:0] user_slot, [39:8] now_seconds
	input  wire logic [cpt_pkg::IN_DATA_W-1:0]       s_tdata,
	// [1:0] command_class
	input  wire logic [cpt_pkg::CLASS_W-1:0]         s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [0] allowed, [20:1] penalty_now, [28:21] second_count, [31:29] zero
	output logic [cpt_pkg::OUT_DATA_W-1:0]           m_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [cpt_pkg::CFG_DATA_W-1:0]      cfg_data
);

	cpt_pkg::cfg_regs_t regs;
	cpt_pkg::item_t     q_item;
	cpt_pkg::result_t   result;
	logic               q_valid;
	logic               q_pop;
	logic               clear_busy;

	cpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	cpt_front #(
		.USER_SLOTS (USER_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.regs       (regs),
		.clear_busy (clear_busy),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	cpt_back #(
		.USER_SLOTS (USER_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.regs       (regs),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.clear_busy (clear_busy),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.result     (result)
	);

	assign m_tdata = {3'b000, result.second_count, result.penalty_now, result.allowed};

endmodule

`default_nettype wire

// ===== sv/cpt_cfg.sv =====
// configuration register file for the command penalty throttle
`default_nettype none

module cpt_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cpt_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [cpt_pkg::CFG_DATA_W-1:0]      cfg_data,
	output cpt_pkg::cfg_regs_t                       regs
);

	cpt_pkg::cfg_regs_t regs_q;
	logic               wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.burst_limit  <= cpt_pkg::RST_BURST_LIMIT;
			regs_q.normal_cost  <= cpt_pkg::RST_NORMAL_COST;
			regs_q.join_cost    <= cpt_pkg::RST_JOIN_COST;
			regs_q.message_cost <= cpt_pkg::RST_MESSAGE_COST;
			regs_q.notice_cost  <= cpt_pkg::RST_NOTICE_COST;
			regs_q.recover_rate <= cpt_pkg::RST_RECOVER_RATE;
		end else if (wr_en) begin
			// indexes past the list are dropped
			unique case (cfg_index)
				cpt_pkg::REG_BURST_LIMIT:  regs_q.burst_limit  <= cfg_data[cpt_pkg::LIMIT_W-1:0];
				cpt_pkg::REG_NORMAL_COST:  regs_q.normal_cost  <= cfg_data;
				cpt_pkg::REG_JOIN_COST:    regs_q.join_cost    <= cfg_data;
				cpt_pkg::REG_MESSAGE_COST: regs_q.message_cost <= cfg_data;
				cpt_pkg::REG_NOTICE_COST:  regs_q.notice_cost  <= cfg_data;
				cpt_pkg::REG_RECOVER_RATE: regs_q.recover_rate <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/cpt_front.sv =====
// front end: accepts commands, classifies them and queues them for the back end
`default_nettype none

module cpt_front #(
	parameter int unsigned USER_SLOTS = cpt_pkg::DEF_USER_SLOTS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [cpt_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire logic [cpt_pkg::CLASS_W-1:0]       s_tuser,
	input  wire cpt_pkg::cfg_regs_t                regs,
	input  wire logic                              clear_busy,
	output logic                                   q_valid,
	output cpt_pkg::item_t                         q_item,
	input  wire logic                              q_pop
);

	localparam int unsigned DEPTH = 2;

	cpt_pkg::item_t    fifo_q [DEPTH];
	cpt_pkg::item_t    item_w;
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic [cpt_pkg::SLOT_W-1:0] slot_w;

	assign slot_w   = s_tdata[cpt_pkg::SLOT_W-1:0];
	assign s_tready = !clear_busy && (count_q != 2'(DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_comb begin
		item_w.slot     = slot_w;
		item_w.now      = s_tdata[cpt_pkg::SLOT_W +: cpt_pkg::TIME_W];
		item_w.in_range = (32'(slot_w) < USER_SLOTS);
		unique case (s_tuser)
			cpt_pkg::CLS_NORMAL:  item_w.cost = regs.normal_cost;
			cpt_pkg::CLS_JOIN:    item_w.cost = regs.join_cost;
			cpt_pkg::CLS_MESSAGE: item_w.cost = regs.message_cost;
			cpt_pkg::CLS_NOTICE:  item_w.cost = regs.notice_cost;
			default:              item_w.cost = regs.normal_cost;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			priority if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (q_pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_w;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (count_q != 2'd0))
		else $error("pop from empty queue");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !push)
		else $error("command taken during table clear");

endmodule

`default_nettype wire

// ===== sv/cpt_back.sv =====
// back end: per-user table update, penalty drain and result register
`default_nettype none

module cpt_back #(
	parameter int unsigned USER_SLOTS = cpt_pkg::DEF_USER_SLOTS
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire cpt_pkg::cfg_regs_t                regs,
	input  wire logic                              q_valid,
	input  wire cpt_pkg::item_t                    q_item,
	output logic                                   q_pop,
	output logic                                   clear_busy,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output cpt_pkg::result_t                       result
);

	localparam int unsigned IDX_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USER_SLOTS - 1);

	cpt_pkg::back_state_t state_q, state_d;

	cpt_pkg::entry_t mem [USER_SLOTS];
	cpt_pkg::entry_t rd_q;
	cpt_pkg::entry_t wr_entry;
	cpt_pkg::item_t  item_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] item_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             mem_we;
	logic             rd_en;
	logic             commit;
	logic             out_free;

	logic [cpt_pkg::PROD_W-1:0]    product_q;
	logic                          later_q;
	logic                          same_q;
	logic [cpt_pkg::PENALTY_W-1:0] pen_drained_q;
	logic [cpt_pkg::PENALTY_W:0]   sum_w;
	logic [cpt_pkg::PENALTY_W-1:0] pen_w;
	logic [cpt_pkg::COUNT_W-1:0]   cnt_w;
	logic [cpt_pkg::TIME_W-1:0]    elapsed_w;

	cpt_pkg::result_t result_q;
	cpt_pkg::result_t result_w;
	logic             out_valid_q;

	assign item_addr  = IDX_W'(item_q.slot);
	assign out_free   = !out_valid_q || m_tready;
	assign clear_busy = (state_q == cpt_pkg::BK_CLEAR);
	assign m_tvalid   = out_valid_q;
	assign result     = result_q;
	assign elapsed_w  = item_q.now - rd_q.last_seen;

	// next state and control
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			cpt_pkg::BK_CLEAR: begin
				if (clr_addr_q == LAST_IDX)
					state_d = cpt_pkg::BK_IDLE;
			end
			cpt_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_item.in_range ? cpt_pkg::BK_READ : cpt_pkg::BK_COMMIT;
				end
			end
			cpt_pkg::BK_READ: begin
				rd_en   = 1'b1;
				state_d = cpt_pkg::BK_MUL;
			end
			cpt_pkg::BK_MUL:   state_d = cpt_pkg::BK_DRAIN;
			cpt_pkg::BK_DRAIN: state_d = cpt_pkg::BK_COMMIT;
			cpt_pkg::BK_COMMIT: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = cpt_pkg::BK_IDLE;
				end
			end
			default: state_d = cpt_pkg::BK_IDLE;
		endcase
	end

	// add class cost, saturate, bump the per-second counter
	always_comb begin
		sum_w = {1'b0, pen_drained_q} + (cpt_pkg::PENALTY_W + 1)'(item_q.cost);
		pen_w = sum_w[cpt_pkg::PENALTY_W] ? cpt_pkg::PENALTY_MAX
			: sum_w[cpt_pkg::PENALTY_W-1:0];
		if (same_q)
			cnt_w = (rd_q.count == cpt_pkg::COUNT_MAX) ? rd_q.count
				: rd_q.count + cpt_pkg::COUNT_W'(1);
		else
			cnt_w = cpt_pkg::COUNT_W'(1);

		if (item_q.in_range) begin
			result_w.allowed      = (cnt_w <= regs.burst_limit)
				&& (pen_w < cpt_pkg::PENALTY_BLOCK);
			result_w.penalty_now  = pen_w;
			result_w.second_count = cnt_w;
		end else begin
			result_w = '0;
		end

		wr_entry.last_seen = item_q.now;
		wr_entry.penalty   = pen_w;
		wr_entry.count     = cnt_w;
		if (clear_busy) begin
			wr_entry = '0;
			wr_addr  = clr_addr_q;
			mem_we   = 1'b1;
		end else begin
			wr_addr  = item_addr;
			mem_we   = commit && item_q.in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cpt_pkg::BK_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_busy)
				clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (commit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// user table
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_entry;
		if (rd_en)
			rd_q <= mem[item_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop)
			item_q <= q_item;
		if (state_q == cpt_pkg::BK_MUL) begin
			product_q <= cpt_pkg::PROD_W'(elapsed_w) * cpt_pkg::PROD_W'(regs.recover_rate);
			later_q   <= (item_q.now > rd_q.last_seen);
			same_q    <= (item_q.now == rd_q.last_seen);
		end
		if (state_q == cpt_pkg::BK_DRAIN) begin
			// drain only when time moved forward, floor at zero
			if (!later_q)
				pen_drained_q <= rd_q.penalty;
			else if (product_q >= cpt_pkg::PROD_W'(rd_q.penalty))
				pen_drained_q <= '0;
			else
				pen_drained_q <= rd_q.penalty - product_q[cpt_pkg::PENALTY_W-1:0];
		end
		if (commit)
			result_q <= result_w;
	end

	a_commit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q)
		else $error("commit did not load the result register");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> (!q_pop && !commit))
		else $error("command processed during table clear");

	a_refused_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !item_q.in_range) |-> !mem_we)
		else $error("out-of-range slot wrote the table");

endmodule

`default_nettype wire
